// ===== hw/rtl/mtrr_pkg.sv =====
package mtrr_pkg;

  // store and frame sizing
  localparam int STORE_BYTES = 256;
  localparam int FRAME_MAX   = 262;
  localparam int HDR_LEN     = 13;

  localparam int POS_W   = $clog2(FRAME_MAX + 1);
  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int HDR_IW  = $clog2(HDR_LEN);
  localparam int REPLY_W = 9;
  localparam int CMP_A   = (POS_W > ADDR_W + 1) ? POS_W : ADDR_W + 1;
  localparam int CMP_W   = (CMP_A > REPLY_W) ? CMP_A : REPLY_W;

  // function codes and reply layout
  localparam logic [7:0] FC_READ  = 8'd3;
  localparam logic [7:0] FC_WRITE = 8'd16;
  localparam logic [7:0] QTY_MAX  = 8'd125;
  localparam int READ_HDR     = 9;   // bytes ahead of register data in a read reply
  localparam int RD_PDU_FIXED = 3;   // unit id, function code, byte count
  localparam int WRITE_LEN    = 12;
  localparam int WR_PDU_LEN   = 6;

  // header byte positions
  localparam int HB_LEN_HI = 4;
  localparam int HB_LEN_LO = 5;
  localparam int HB_UNIT   = 6;
  localparam int HB_FC     = 7;
  localparam int HB_CNT    = 8;
  localparam int HB_QTY    = 11;
  localparam int HB_BYTES  = 12;

  // pending reply kind
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // queue sizing
  localparam int Q_AW     = 1;
  localparam int Q_DEPTH  = 1 << Q_AW;
  localparam int OQ_AW    = 2;
  localparam int OQ_DEPTH = 1 << OQ_AW;

  typedef struct packed {
    logic       is_pull;
    logic [7:0] data;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic [OQ_AW:0] oq_cnt;
    logic           pending;
  } stat_t;

endpackage

// ===== hw/rtl/mtrr_ram.sv =====
module mtrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hw/rtl/mtrr_front.sv =====
module mtrr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic [0:0]      in_tuser,
  output logic            q_vld,
  output mtrr_pkg::item_t q_item,
  input  logic            q_pop
);
  import mtrr_pkg::*;

  item_t           q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            push;
  item_t           in_item;

  assign in_tready = (cnt_r != (Q_AW + 1)'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_vld     = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // classify: pulls versus request bytes
  always_comb begin
    in_item.is_pull   = in_tuser[0];
    in_item.data      = in_tdata;
    in_item.frame_end = in_tlast && !in_tuser[0];
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW + 1)'(push) - (Q_AW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== hw/rtl/mtrr_exec.sv =====
module mtrr_exec (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_vld,
  input  mtrr_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output mtrr_pkg::stat_t stat
);
  import mtrr_pkg::*;

  // frame and reply state
  logic [7:0]         hdr_r [HDR_LEN];
  logic [7:0]         hdr_nxt [HDR_LEN];
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [REPLY_W-1:0] idx_r, idx_nxt;
  logic [REPLY_W-1:0] len_r, len_nxt;
  logic               vld_r [STORE_BYTES];

  // store access
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [7:0]         rdata;

  // result stage
  logic               sb_vld_r, sb_vld_nxt;
  logic [7:0]         sb_byte_r, sb_byte_nxt;
  logic               sb_sel_r, sb_sel_nxt;
  logic               sb_ent_r, sb_ent_nxt;
  logic               sb_last_r, sb_last_nxt;
  logic [7:0]         res_byte;

  // output queue
  logic [8:0]         oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wr_r, oq_rd_r;
  logic [OQ_AW:0]     oq_cnt_r, oq_cnt_nxt;
  logic               oq_pop;
  logic [OQ_AW+1:0]   credit_use;

  // scratch
  logic [CMP_W-1:0]   widx;
  logic [CMP_W-1:0]   sidx;
  logic [7:0]         qty;
  logic [7:0]         nbytes;
  logic [REPLY_W-1:0] idx_inc;
  logic               is_last;

  // issue only while the output queue has room for everything in flight
  assign credit_use = {1'b0, oq_cnt_r} + (OQ_AW + 2)'(sb_vld_r);
  assign q_pop      = q_vld && (credit_use < (OQ_AW + 2)'(OQ_DEPTH));

  always_comb begin
    hdr_nxt     = hdr_r;
    pos_nxt     = pos_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    len_nxt     = len_r;
    we          = 1'b0;
    waddr       = '0;
    re          = 1'b0;
    raddr       = '0;
    sb_vld_nxt  = 1'b0;
    sb_byte_nxt = 8'd0;
    sb_sel_nxt  = 1'b0;
    sb_last_nxt = 1'b0;
    widx        = CMP_W'(pos_r) - CMP_W'(HDR_LEN);
    sidx        = CMP_W'(idx_r) - CMP_W'(READ_HDR);
    qty         = (hdr_r[HB_QTY] > QTY_MAX) ? QTY_MAX : hdr_r[HB_QTY];
    nbytes      = 8'(len_r - REPLY_W'(READ_HDR));
    idx_inc     = idx_r + 1'b1;
    is_last     = (idx_inc >= len_r);

    if (q_pop && !q_item.is_pull) begin
      // any request byte drops a pending reply
      kind_nxt = KIND_NONE;
      idx_nxt  = '0;
      len_nxt  = '0;
      if (pos_r < POS_W'(FRAME_MAX)) begin
        if (pos_r < POS_W'(HDR_LEN)) begin
          hdr_nxt[pos_r[HDR_IW-1:0]] = q_item.data;
        end else if (hdr_r[HB_FC] == FC_WRITE) begin
          if ((widx < CMP_W'(hdr_r[HB_BYTES])) && (widx < CMP_W'(STORE_BYTES))) begin
            we    = 1'b1;
            waddr = widx[ADDR_W-1:0];
          end
        end
        pos_nxt = pos_r + 1'b1;
      end
      if (q_item.frame_end) begin
        qty = (hdr_nxt[HB_QTY] > QTY_MAX) ? QTY_MAX : hdr_nxt[HB_QTY];
        if (hdr_nxt[HB_FC] == FC_READ) begin
          kind_nxt = KIND_READ;
          len_nxt  = REPLY_W'(READ_HDR) + REPLY_W'({qty, 1'b0});
        end else if (hdr_nxt[HB_FC] == FC_WRITE) begin
          kind_nxt = KIND_WRITE;
          len_nxt  = REPLY_W'(WRITE_LEN);
        end
        hdr_nxt[HB_FC] = 8'd0;
        pos_nxt        = '0;
      end
    end else if (q_pop && (kind_r != KIND_NONE)) begin
      sb_vld_nxt  = 1'b1;
      sb_last_nxt = is_last;
      idx_nxt     = is_last ? '0 : idx_inc;
      if (is_last) begin
        kind_nxt = KIND_NONE;
        len_nxt  = '0;
      end
      if (kind_r == KIND_READ) begin
        priority if ((idx_r < REPLY_W'(HB_LEN_HI)) || (idx_r == REPLY_W'(HB_UNIT))) begin
          sb_byte_nxt = hdr_r[idx_r[HDR_IW-1:0]];
        end else if (idx_r == REPLY_W'(HB_LEN_HI)) begin
          sb_byte_nxt = 8'd0;
        end else if (idx_r == REPLY_W'(HB_LEN_LO)) begin
          sb_byte_nxt = nbytes + 8'(RD_PDU_FIXED);
        end else if (idx_r == REPLY_W'(HB_FC)) begin
          sb_byte_nxt = FC_READ;
        end else if (idx_r == REPLY_W'(HB_CNT)) begin
          sb_byte_nxt = nbytes;
        end else if (sidx < CMP_W'(STORE_BYTES)) begin
          sb_sel_nxt = 1'b1;
          re         = 1'b1;
          raddr      = sidx[ADDR_W-1:0];
        end else begin
          sb_byte_nxt = 8'd0;
        end
      end else begin
        priority if (idx_r == REPLY_W'(HB_LEN_HI)) begin
          sb_byte_nxt = 8'd0;
        end else if (idx_r == REPLY_W'(HB_LEN_LO)) begin
          sb_byte_nxt = 8'(WR_PDU_LEN);
        end else if (idx_r == REPLY_W'(HB_FC)) begin
          sb_byte_nxt = FC_WRITE;
        end else if (idx_r < REPLY_W'(WRITE_LEN)) begin
          sb_byte_nxt = hdr_r[idx_r[HDR_IW-1:0]];
        end else begin
          sb_byte_nxt = 8'd0;
        end
      end
    end
    // entries never written since reset read as zero
    sb_ent_nxt = vld_r[raddr];
  end

  mtrr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_item.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_r[i] <= 8'd0;
      end
      for (int i = 0; i < STORE_BYTES; i++) begin
        vld_r[i] <= 1'b0;
      end
      pos_r    <= '0;
      kind_r   <= KIND_NONE;
      idx_r    <= '0;
      len_r    <= '0;
      sb_vld_r <= 1'b0;
    end else begin
      hdr_r    <= hdr_nxt;
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      sb_vld_r <= sb_vld_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_byte_r <= sb_byte_nxt;
    sb_sel_r  <= sb_sel_nxt;
    sb_ent_r  <= sb_ent_nxt;
    sb_last_r <= sb_last_nxt;
  end

  assign res_byte = sb_sel_r ? (sb_ent_r ? rdata : 8'd0) : sb_byte_r;

  // output queue, credit above guarantees room for every push
  assign oq_pop     = out_tvalid && out_tready;
  assign oq_cnt_nxt = oq_cnt_r + (OQ_AW + 1)'(sb_vld_r) - (OQ_AW + 1)'(oq_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (sb_vld_r) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sb_vld_r) begin
      oq_mem_r[oq_wr_r] <= {sb_last_r, res_byte};
    end
  end

  assign out_tvalid   = (oq_cnt_r != '0);
  assign out_tdata    = oq_mem_r[oq_rd_r][7:0];
  assign out_tlast    = oq_mem_r[oq_rd_r][8];
  assign stat.oq_cnt  = oq_cnt_r;
  assign stat.pending = (kind_r != KIND_NONE);

endmodule

// ===== hw/rtl/modbus_tcp_register_responder_core.sv =====
// Modbus TCP register responder for read holding registers (function 3) and
// write multiple registers (function 16). Request bytes enter with in_tuser = 0
// and in_tlast on the final byte of the frame; a word with in_tuser = 1 pulls the
// next byte of the pending reply, which leaves on out_tdata with out_tlast on its
// final byte (a pull with no reply pending yields nothing). The block takes one
// word per clock in steady state: a two-entry input queue feeds the execute
// stage, which updates frame state and the register store as each word issues, and the
// reply byte passes through the result stage, with the registered store read,
// into a four-entry output queue. Issue pauses only when the output queue plus
// the byte in flight would fill it, so with out_tready held high the rate is
// one word per cycle. The store starts at zero after reset with no clearing
// pass: per-entry valid flags are cleared by reset and an entry never written
// reads as zero. The start address of a request is not used: reads return the
// store from byte 0 and writes fill it from byte 0.
module modbus_tcp_register_responder_core (
  input  logic       clk,
  input  logic       rst_n,
  // request and pull words
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // frame_end
  input  logic [0:0] in_tuser,   // [0] cmd: 0 request byte, 1 pull
  // reply bytes
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] resp_byte
  output logic       out_tlast   // resp_last
);
  import mtrr_pkg::*;

  logic  q_vld;
  item_t q_item;
  logic  q_pop;
  stat_t stat;

  // front: input queue and word classification
  mtrr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: frame tracking, register store, reply generation
  mtrr_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (stat)
  );

  // output queue never holds more than its depth
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.oq_cnt <= (OQ_AW + 1)'(OQ_DEPTH))
    else $error("output queue overflow");

  // reply valid follows the queue fill level
  a_oq_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid == (stat.oq_cnt != '0))
    else $error("out_tvalid disagrees with output queue");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !stat.pending)
    else $error("output or pending reply after reset");

  // a request byte that does not end a frame cancels any pending reply
  a_req_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !q_item.is_pull && !q_item.frame_end |=> !stat.pending)
    else $error("reply still pending after request byte");

endmodule

// ===== verif/tb_modbus_tcp_register_responder_core.sv =====
`timescale 1ns / 100ps

module tb_modbus_tcp_register_responder_core;
  import mtrr_pkg::*;

  localparam int RUN_WORDS    = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } reply_word_t;

  // mirror of the responder: frame tracking, register store, pending reply
  class reply_scoreboard;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  regs [STORE_BYTES];
    int unsigned pos;
    logic [1:0]  kind;
    int unsigned idx;
    int unsigned len;
    reply_word_t due [$];
    int unsigned errors;

    function new();
      foreach (hdr[i]) hdr[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pos    = 0;
      kind   = KIND_NONE;
      idx    = 0;
      len    = 0;
      errors = 0;
    endfunction

    function int unsigned reply_left();
      return (kind == KIND_NONE) ? 0 : len - idx;
    endfunction

    function int unsigned waiting();
      return due.size();
    endfunction

    function logic [7:0] reply_at(int unsigned k);
      int unsigned n;
      n = len - READ_HDR;
      if (kind == KIND_READ) begin
        if (k < HB_LEN_HI || k == HB_UNIT) return hdr[k];
        if (k == HB_LEN_HI) return 8'd0;
        if (k == HB_LEN_LO) return 8'(RD_PDU_FIXED + n);
        if (k == HB_FC) return FC_READ;
        if (k == HB_CNT) return 8'(n);
        return (k - READ_HDR < STORE_BYTES) ? regs[k - READ_HDR] : 8'd0;
      end
      if (k == HB_LEN_HI) return 8'd0;
      if (k == HB_LEN_LO) return 8'(WR_PDU_LEN);
      if (k == HB_FC) return FC_WRITE;
      return (k < WRITE_LEN) ? hdr[k] : 8'd0;
    endfunction

    // end of request frame: queue a reply for the two known function codes
    function void frame_closed();
      int unsigned q;
      q = hdr[HB_QTY];
      if (q > QTY_MAX) q = QTY_MAX;
      if (hdr[HB_FC] == FC_READ) begin
        kind = KIND_READ;
        len  = READ_HDR + 2 * q;
        idx  = 0;
      end else if (hdr[HB_FC] == FC_WRITE) begin
        kind = KIND_WRITE;
        len  = WRITE_LEN;
        idx  = 0;
      end
      hdr[HB_FC] = 8'd0;
      pos = 0;
    endfunction

    // accepted input word; returns 1 when the word had any effect
    function bit note_word(bit is_pull, logic [7:0] data, bit eof);
      int unsigned off;
      reply_word_t w;
      if (!is_pull) begin
        // any request byte drops the pending reply
        kind = KIND_NONE;
        idx  = 0;
        len  = 0;
        if (pos < FRAME_MAX) begin
          if (pos < HDR_LEN) begin
            hdr[pos] = data;
          end else if (hdr[HB_FC] == FC_WRITE) begin
            off = pos - HDR_LEN;
            if (off < hdr[HB_BYTES] && off < STORE_BYTES) regs[off] = data;
          end
          pos++;
        end
        if (eof) frame_closed();
        return 1'b1;
      end
      if (kind == KIND_NONE) return 1'b0;
      w.data = reply_at(idx);
      idx++;
      if (idx >= len) begin
        w.eof = 1'b1;
        kind  = KIND_NONE;
        idx   = 0;
        len   = 0;
      end else begin
        w.eof = 1'b0;
      end
      due.push_back(w);
      return 1'b1;
    endfunction

    function void check_reply(logic [7:0] data, logic eof);
      reply_word_t w;
      if (due.size() == 0) begin
        $display("%0t: unexpected reply word, expected none, actual data %02h last %0b",
                 $time, data, eof);
        errors++;
        return;
      end
      w = due.pop_front();
      if (data !== w.data) begin
        $display("%0t: reply data mismatch, expected %02h, actual %02h", $time, w.data, data);
        errors++;
      end
      if (eof !== w.eof) begin
        $display("%0t: reply last mismatch, expected %0b, actual %0b", $time, w.eof, eof);
        errors++;
      end
    endfunction

    function void close_out();
      if (due.size() != 0) begin
        $display("%0t: reply words missing, expected %0d more, actual 0", $time, due.size());
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;   // frame_end
  logic [0:0] in_tuser;   // [0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] resp_byte
  logic       out_tlast;  // resp_last

  reply_scoreboard board = new();
  int unsigned     words_done;
  bit              in_quiet;
  bit              out_quiet;
  int unsigned     stall_left;

  modbus_tcp_register_responder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly back to back, now and then a short or a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input bit is_pull, input logic [7:0] data, input bit eof);
    int unsigned gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= is_pull;
    in_tdata  <= data;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    if (board.note_word(is_pull, data, eof)) words_done++;
  endtask

  // request frame of flen bytes; fill < 0 gives random filler bytes
  task automatic send_frame(input logic [7:0] fc, input logic [7:0] qty,
                            input logic [7:0] cnt, input int unsigned flen, input int fill);
    logic [7:0] b;
    for (int unsigned p = 0; p < flen; p++) begin
      if (p == HB_FC) b = fc;
      else if (p == HB_QTY) b = qty;
      else if (p == HB_BYTES) b = cnt;
      else if (fill < 0) b = 8'($urandom);
      else b = 8'(fill);
      send_word(1'b0, b, p == flen - 1);
    end
  endtask

  // pull the pending reply, all of it (plus maybe a dry pull) or only part
  task automatic pull_reply(input bit whole);
    int unsigned n;
    int unsigned extra;
    n = board.reply_left();
    if (!whole && n > 1) n = $urandom_range(1, n - 1);
    extra = whole ? $urandom_range(0, 1) : 0;
    repeat (n + extra) send_word(1'b1, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned s;
    logic [7:0]  qty;
    logic [7:0]  cnt;
    logic [7:0]  fc;
    int unsigned flen;
    if ($urandom_range(0, 19) == 0) in_quiet = !in_quiet;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 40) begin
      // read holding registers, mostly small quantities
      if (s < 90) qty = 8'($urandom_range(0, 8));
      else if (s < 97) qty = 8'($urandom_range(9, 40));
      else qty = 8'($urandom_range(0, 255));
      s = $urandom_range(0, 99);
      if (s < 80) flen = HDR_LEN;
      else if (s < 90) flen = HDR_LEN + $urandom_range(1, 4);
      else flen = $urandom_range(HB_FC + 1, HDR_LEN - 1);
      send_frame(FC_READ, qty, 8'($urandom), flen, -1);
    end else if (r < 75) begin
      // write multiple registers
      if (s < 85) cnt = 8'($urandom_range(0, 16));
      else if (s < 97) cnt = 8'($urandom_range(17, 64));
      else cnt = 8'($urandom_range(0, 255));
      s = $urandom_range(0, 99);
      if (s < 80) flen = HDR_LEN + cnt;
      else if (s < 99) flen = HDR_LEN + $urandom_range(0, cnt + 4);
      else flen = FRAME_MAX + $urandom_range(0, 20);
      send_frame(FC_WRITE, 8'($urandom), cnt, flen, -1);
    end else if (r < 85) begin
      // unsupported function code
      do fc = 8'($urandom); while (fc == FC_READ || fc == FC_WRITE);
      send_frame(fc, 8'($urandom), 8'($urandom), HDR_LEN + $urandom_range(0, 4), -1);
    end else if (r < 92) begin
      // too short to carry a function code
      fc = (s < 50) ? FC_READ : FC_WRITE;
      send_frame(fc, 8'($urandom), 8'($urandom), $urandom_range(1, HB_FC), -1);
    end else begin
      // noise words of either kind
      repeat ($urandom_range(1, 6)) send_word(1'($urandom), 8'($urandom), 1'($urandom));
    end
    if (board.reply_left() != 0) pull_reply($urandom_range(0, 99) < 85);
  endtask

  // reply side: random stalls, with stretches of none
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) out_quiet <= !out_quiet;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!out_quiet && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 29);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reply(out_tdata, out_tlast);
  end

  // progress watchdog
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = '0;
    out_tready = 1'b0;
    stall_left = 0;
    in_quiet   = 1'b0;
    out_quiet  = 1'b0;
    words_done = 0;
    rst_n      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pulls with nothing pending
    send_word(1'b1, 8'h00, 1'b0);
    send_word(1'b1, 8'hff, 1'b1);
    // zero-quantity read of the cleared store
    send_frame(FC_READ, 8'd0, 8'd0, HDR_LEN, 0);
    pull_reply(1'b1);
    // writes with all-ones and then all-zeros data over it, then read the zeros back
    send_frame(FC_WRITE, 8'hff, 8'd4, HDR_LEN + 4, 255);
    pull_reply(1'b1);
    send_frame(FC_WRITE, 8'h00, 8'd6, HDR_LEN + 6, 0);
    pull_reply(1'b1);
    send_frame(FC_READ, 8'd3, 8'h5a, HDR_LEN, -1);
    pull_reply(1'b1);
    // quantity above the limit saturates
    send_frame(FC_READ, 8'd255, 8'd0, HDR_LEN, 255);
    pull_reply(1'b1);
    // short frame and unknown code queue nothing
    send_frame(FC_READ, 8'd2, 8'd0, HB_FC, -1);
    send_word(1'b1, 8'h00, 1'b0);
    send_frame(8'd4, 8'd2, 8'd2, HDR_LEN, -1);
    send_word(1'b1, 8'h00, 1'b0);
    // new request while a reply is half read
    send_frame(FC_READ, 8'd2, 8'd0, HDR_LEN, -1);
    pull_reply(1'b0);
    send_frame(FC_WRITE, 8'd1, 8'd2, HDR_LEN + 6, -1);
    pull_reply(1'b1);
    // frame longer than the position limit, full byte count
    send_frame(FC_WRITE, 8'd0, 8'd255, FRAME_MAX + 38, -1);
    pull_reply(1'b1);
    send_frame(FC_READ, QTY_MAX, 8'd0, HDR_LEN, -1);
    pull_reply(1'b1);
    // header cut after the quantity byte keeps the old byte count
    send_frame(FC_READ, 8'd1, 8'd0, HB_QTY + 1, -1);
    pull_reply(1'b1);

    while (words_done < RUN_WORDS) random_frame();
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (board.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();
    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
